FILE: src/sle_pkg.sv
// shared types and constants for the sprite line evaluation block
// no dependencies; imported by every module of the block but sle_ram

package sle_pkg;

  // attribute memory: 256 bytes held as 64 words of four byte lanes
  localparam int OAM_WORDS = 64;
  localparam int WORD_AW   = 6;
  localparam int LANES     = 4;

  localparam logic [7:0] NONE_BYTE    = 8'hFF;
  localparam logic [7:0] SHORT_HEIGHT = 8'd8;
  localparam logic [7:0] TALL_HEIGHT  = 8'd16;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_EMIT
  } sle_state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] oam_address;
    logic [7:0] oam_data;
    logic [7:0] scanline;
  } sle_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       found;
    logic [2:0] slot;
    logic [7:0] sprite_y;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attr;
    logic [7:0] sprite_x;
    logic [3:0] line_count;
    logic       zero_selected;
    logic       overflow;
    logic       last;
  } sle_out_t;

  // one access per cycle to all four lanes at one word address
  typedef struct packed {
    logic [LANES-1:0]   wmask;
    logic [WORD_AW-1:0] addr;
    logic [7:0]         wdata;
  } sle_mem_req_t;

  function automatic sle_out_t blank_result();
    sle_out_t r;
    r.read_data     = 8'd0;
    r.found         = 1'b0;
    r.slot          = 3'd0;
    r.sprite_y      = NONE_BYTE;
    r.sprite_tile   = NONE_BYTE;
    r.sprite_attr   = NONE_BYTE;
    r.sprite_x      = NONE_BYTE;
    r.line_count    = 4'd0;
    r.zero_selected = 1'b0;
    r.overflow      = 1'b0;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage

FILE: src/sprite_line_evaluation.sv
// top level of the sprite line evaluation block: config register, sequencer, memory
// depends on sle_pkg, sle_ctrl, sle_attr_mem (sle_ram)
//
//  channel   handshake                 payload
//  command   start / busy              item   (sle_in_t)
//  result    result_valid, no stall    result (sle_out_t)
//  config    cfg_wen                   cfg_wdata (tall_sprites)
//
// after reset busy stays high while the memory is cleared word by word
// write: busy is not raised; the block stays idle for the next command
// read: busy while in ST_READ, which loads the result register; the strobe is registered
// evaluate: busy through scan and replay (n picked sprites), one y byte read per
//   cycle from the memory port during the scan, then one re-read per picked sprite;
//   a ninth in-range entry ends the scan early; results strobe one per cycle

module sprite_line_evaluation
  import sle_pkg::*;
#(
  parameter int NUM_ENTRIES  = 64,
  parameter int MAX_PER_LINE = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_wen,
  input  logic     cfg_wdata,
  input  logic     start,
  input  sle_in_t  item,
  output logic     busy,
  output logic     result_valid,
  output sle_out_t result
);

  logic               tall_sprites;
  sle_mem_req_t       mem_req;
  logic [8*LANES-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_wen) begin
      tall_sprites <= cfg_wdata;
    end
  end

  sle_ctrl #(
    .NUM_ENTRIES  (NUM_ENTRIES),
    .MAX_PER_LINE (MAX_PER_LINE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tall_sprites (tall_sprites),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

  sle_attr_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

FILE: src/sle_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/sle_attr_mem.sv
// sprite attribute memory: four byte lanes (y, tile, attr, x) of 64 words
// depends on sle_pkg and sle_ram

module sle_attr_mem
  import sle_pkg::*;
(
  input  logic                 clk,
  input  sle_mem_req_t         req,
  output logic [8*LANES-1:0]   rdata
);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    sle_ram #(
      .WIDTH (8),
      .DEPTH (OAM_WORDS)
    ) u_ram (
      .clk   (clk),
      .we    (req.wmask[g]),
      .addr  (req.addr),
      .wdata (req.wdata),
      .rdata (rdata[8*g +: 8])
    );
  end

endmodule

FILE: src/sle_ctrl.sv
// command sequencer: memory clear, byte access, scanline scan, picked-list replay, result register
// depends on sle_pkg; drives the attribute memory through sle_mem_req_t

module sle_ctrl
  import sle_pkg::*;
#(
  parameter int NUM_ENTRIES  = 64,
  parameter int MAX_PER_LINE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tall_sprites,
  input  logic               start,
  input  sle_in_t            item,
  output logic               busy,
  output sle_mem_req_t       mem_req,
  input  logic [8*LANES-1:0] mem_rdata,
  output logic               result_valid,
  output sle_out_t           result
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int KW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
  localparam int CW = $clog2(MAX_PER_LINE + 1);

  sle_state_t         state, state_next;
  logic [WORD_AW-1:0] clr_idx;
  sle_in_t            op_q;
  logic [IW-1:0]      scan_idx;
  logic [CW-1:0]      count;
  logic               zero_q;
  logic               ovf_q;
  logic [IW-1:0]      picked [MAX_PER_LINE];
  logic [KW-1:0]      emit_k;

  logic          accept;
  logic [8:0]    diff;
  logic [7:0]    height;
  logic          in_range, cap_full, hit_take, hit_ovf, last_entry, scan_done;
  logic [CW-1:0] count_upd;
  logic [IW-1:0] first_pick;
  logic          emit_last;
  logic [KW-1:0] emit_nxt;
  logic [KW+2:0] slot_ext;
  logic [CW+3:0] count_ext;
  logic          result_load;
  sle_out_t      result_next;

  // entries past the 64th alias back onto the memory, byte addresses wrap
  function automatic logic [WORD_AW-1:0] entry_word(input logic [IW-1:0] idx);
    logic [IW+WORD_AW-1:0] ext;
    ext = {{WORD_AW{1'b0}}, idx};
    return ext[WORD_AW-1:0];
  endfunction

  assign accept = start && !busy;

  // y compare on the lane read back this cycle
  assign height     = tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT;
  assign diff       = {1'b0, op_q.scanline} - {1'b0, mem_rdata[7:0]};
  assign in_range   = !diff[8] && (diff[7:0] < height);
  assign cap_full   = (count == CW'(MAX_PER_LINE));
  assign hit_take   = in_range && !cap_full;
  assign hit_ovf    = in_range && cap_full;
  assign last_entry = (scan_idx == IW'(NUM_ENTRIES - 1));
  assign scan_done  = hit_ovf || last_entry;
  assign count_upd  = hit_take ? count + 1'b1 : count;
  // forward the entry picked in this very cycle
  assign first_pick = (count == '0) ? scan_idx : picked[0];

  assign emit_last = ((CW'(emit_k) + CW'(1)) == count);
  assign emit_nxt  = emit_last ? emit_k : emit_k + 1'b1;
  assign slot_ext  = {3'b000, emit_k};
  assign count_ext = {4'b0000, count};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == WORD_AW'(OAM_WORDS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            CMD_READ: state_next = ST_READ;
            CMD_EVAL: state_next = ST_SCAN;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_done) state_next = (count_upd == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != ST_IDLE);
    mem_req.wmask = '0;
    mem_req.addr  = '0;
    mem_req.wdata = item.oam_data;
    result_load   = 1'b0;
    result_next   = blank_result();
    case (state)
      ST_CLEAR: begin
        mem_req.wmask = '1;
        mem_req.addr  = clr_idx;
        mem_req.wdata = 8'd0;
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            CMD_WRITE: begin
              mem_req.wmask = LANES'(1) << item.oam_address[1:0];
              mem_req.addr  = item.oam_address[7:2];
            end
            CMD_READ: mem_req.addr = item.oam_address[7:2];
            CMD_EVAL: mem_req.addr = entry_word('0);
            default:  mem_req.addr = '0;
          endcase
        end
      end
      ST_READ: begin
        result_load           = 1'b1;
        result_next.read_data = mem_rdata[8*op_q.oam_address[1:0] +: 8];
      end
      ST_SCAN: begin
        mem_req.addr = scan_done ? entry_word(first_pick) : entry_word(scan_idx + 1'b1);
        // nothing in range: a single empty result
        if (scan_done && count_upd == '0) result_load = 1'b1;
      end
      ST_EMIT: begin
        mem_req.addr              = entry_word(picked[emit_nxt]);
        result_load               = 1'b1;
        result_next.found         = 1'b1;
        result_next.slot          = slot_ext[2:0];
        result_next.sprite_y      = mem_rdata[7:0];
        result_next.sprite_tile   = mem_rdata[15:8];
        result_next.sprite_attr   = mem_rdata[23:16];
        result_next.sprite_x      = mem_rdata[31:24];
        result_next.line_count    = count_ext[3:0];
        result_next.zero_selected = zero_q;
        result_next.overflow      = ovf_q;
        result_next.last          = emit_last;
      end
      default: begin
        result_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      scan_idx     <= '0;
      count        <= '0;
      zero_q       <= 1'b0;
      ovf_q        <= 1'b0;
      emit_k       <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_load;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (accept && item.cmd == CMD_EVAL) begin
        scan_idx <= '0;
        count    <= '0;
        zero_q   <= 1'b0;
        ovf_q    <= 1'b0;
      end
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
        count    <= count_upd;
        if (hit_take && scan_idx == '0) zero_q <= 1'b1;
        if (hit_ovf) ovf_q <= 1'b1;
        if (scan_done) emit_k <= '0;
      end
      if (state == ST_EMIT) emit_k <= emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op_q <= item;
    if (state == ST_SCAN && hit_take) picked[count[KW-1:0]] <= scan_idx;
    if (result_load) result <= result_next;
  end

  // a run's final result is never followed directly by another
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("result right after a last result");

  a_write_when: assert property (@(posedge clk) disable iff (rst)
    (|mem_req.wmask) |-> (state == ST_CLEAR || state == ST_IDLE))
    else $error("memory write outside clear or idle");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> (CW'(emit_k) < count))
    else $error("replay index past picked count");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PER_LINE))
    else $error("picked count above limit");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_READ || $past(state) == ST_SCAN ||
                      $past(state) == ST_EMIT))
    else $error("result strobe from wrong state");

endmodule

FILE: test/tb_top.sv
// testbench for sprite_line_evaluation: directed script, then random sprite sets
// checked transfer by transfer against a scanline predictor; depends on sle_pkg

module tb_top;
  import sle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 105;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic {ROW_CMD, ROW_TALL} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    sle_in_t    cmd_item;
    bit         typed;
    logic [7:0] typed_rd;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     cfg_wen;
  logic     cfg_wdata;
  logic     start;
  sle_in_t  item;
  logic     busy;
  logic     result_valid;
  sle_out_t result;

  // side channel: expected result typed into the script for the item on the port
  bit         item_typed;
  logic [7:0] item_typed_rd;

  logic [7:0] sprite_mem [256];
  bit         tall_mode;
  sle_out_t   pending_results [$];
  stim_row_t  script [$];

  int mismatches;
  int quiet_cycles;
  int commands_taken;
  int results_checked;
  int overflow_lines;
  int tall_scans;

  sprite_line_evaluation #(
    .NUM_ENTRIES (OAM_WORDS),
    .MAX_PER_LINE(LINE_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic sle_out_t empty_result(logic [7:0] rd);
    sle_out_t r;
    r.read_data     = rd;
    r.found         = 1'b0;
    r.slot          = 3'd0;
    r.sprite_y      = NONE_BYTE;
    r.sprite_tile   = NONE_BYTE;
    r.sprite_attr   = NONE_BYTE;
    r.sprite_x      = NONE_BYTE;
    r.line_count    = 4'd0;
    r.zero_selected = 1'b0;
    r.overflow      = 1'b0;
    r.last          = 1'b1;
    return r;
  endfunction

  task automatic predict_sprite_results(input sle_in_t it);
    int height;
    int count;
    int e;
    int k;
    int y;
    int base;
    bit zero;
    bit ovf;
    bit stop;
    int picked [LINE_LIMIT];
    sle_out_t r;
    case (it.cmd)
      CMD_WRITE: sprite_mem[it.oam_address] = it.oam_data;
      CMD_READ: pending_results.push_back(empty_result(sprite_mem[it.oam_address]));
      CMD_EVAL: begin
        height = tall_mode ? int'(TALL_HEIGHT) : int'(SHORT_HEIGHT);
        count = 0;
        zero = 1'b0;
        ovf = 1'b0;
        stop = 1'b0;
        if (tall_mode) tall_scans++;
        for (e = 0; e < OAM_WORDS && !stop; e++) begin
          y = sprite_mem[8'(e * LANES)];
          if (int'(it.scanline) >= y && int'(it.scanline) - y < height) begin
            // one more in-range entry past the limit ends the scan
            if (count >= LINE_LIMIT) begin
              ovf = 1'b1;
              stop = 1'b1;
            end else begin
              if (e == 0) zero = 1'b1;
              picked[3'(count)] = e * LANES;
              count++;
            end
          end
        end
        if (ovf) overflow_lines++;
        if (count == 0) begin
          pending_results.push_back(empty_result(8'd0));
        end else begin
          for (k = 0; k < count; k++) begin
            base = picked[3'(k)];
            r.read_data     = 8'd0;
            r.found         = 1'b1;
            r.slot          = k[2:0];
            r.sprite_y      = sprite_mem[8'(base)];
            r.sprite_tile   = sprite_mem[8'((base + 1) & 255)];
            r.sprite_attr   = sprite_mem[8'((base + 2) & 255)];
            r.sprite_x      = sprite_mem[8'((base + 3) & 255)];
            r.line_count    = count[3:0];
            r.zero_selected = zero;
            r.overflow      = ovf;
            r.last          = (k == count - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result check first, then the command taken at the same edge
  always @(posedge clk) begin
    sle_out_t want;
    if (!rst) begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("read_data", want.read_data, result.read_data);
          compare_field("found", 8'(want.found), 8'(result.found));
          compare_field("slot", 8'(want.slot), 8'(result.slot));
          compare_field("sprite_y", want.sprite_y, result.sprite_y);
          compare_field("sprite_tile", want.sprite_tile, result.sprite_tile);
          compare_field("sprite_attr", want.sprite_attr, result.sprite_attr);
          compare_field("sprite_x", want.sprite_x, result.sprite_x);
          compare_field("line_count", 8'(want.line_count), 8'(result.line_count));
          compare_field("zero_selected", 8'(want.zero_selected),
                        8'(result.zero_selected));
          compare_field("overflow", 8'(want.overflow), 8'(result.overflow));
          compare_field("last", 8'(want.last), 8'(result.last));
          results_checked++;
        end
      end
      if (start && !busy) begin
        if (item.cmd != CMD_UNUSED) commands_taken++;
        if (item_typed) pending_results.push_back(empty_result(item_typed_rd));
        else predict_sprite_results(item);
      end
      if (cfg_wen) tall_mode = cfg_wdata;
      if ((start && !busy) || result_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input sle_in_t it, input bit typed, input logic [7:0] typed_rd,
                           input int idle_pct);
    @(negedge clk);
    // idle cycles are added one by one, each with the idle chance
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    item_typed <= typed;
    item_typed_rd <= typed_rd;
    do @(posedge clk); while (busy);
  endtask

  // sender holds off until every expected result is in and the block is idle
  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_tall(input bit v);
    wait_all_results();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [1:0] cmd,
                         input logic [7:0] addr, input logic [7:0] data,
                         input logic [7:0] line, input bit typed,
                         input logic [7:0] rd);
    stim_row_t row;
    row.kind = kind;
    row.cmd_item.cmd = cmd;
    row.cmd_item.oam_address = addr;
    row.cmd_item.oam_data = data;
    row.cmd_item.scanline = line;
    row.typed = typed;
    row.typed_rd = rd;
    script.push_back(row);
  endtask

  function automatic sle_in_t random_command(input logic [7:0] center);
    sle_in_t it;
    int pick;
    it.oam_address = 8'($urandom);
    it.oam_data = 8'($urandom);
    it.scanline = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.cmd = CMD_WRITE;
      if ($urandom_range(99) < 60) begin
        it.oam_address = {6'($urandom_range(0, OAM_WORDS - 1)), 2'b00};
        it.oam_data = center - 8'($urandom_range(0, 18));
      end
    end else if (pick < 50) begin
      it.cmd = CMD_READ;
    end else if (pick < 97) begin
      it.cmd = CMD_EVAL;
      if ($urandom_range(99) < 75) it.scanline = center + 8'($urandom_range(0, 6)) - 8'd2;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  initial begin
    sle_in_t    it;
    logic [7:0] center;
    int         sent;
    int         ph;
    int         idle_pct;
    bit         phase_tall [4];

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    item_typed = 1'b0;
    item_typed_rd = 8'd0;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    tall_mode = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    commands_taken = 0;
    results_checked = 0;
    overflow_lines = 0;
    tall_scans = 0;
    foreach (sprite_mem[i]) sprite_mem[i] = 8'd0;

    // after reset every Y is zero, so scanline 0 selects the first eight and overflows
    add_row(ROW_CMD, CMD_READ, 8'h00, 8'h00, 8'h00, 1, 8'h00);
    add_row(ROW_CMD, CMD_READ, 8'hFF, 8'h00, 8'h00, 1, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'hFF, 1, 8'h00);
    add_row(ROW_CMD, CMD_WRITE, 8'hFF, 8'hFF, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_READ, 8'hFF, 8'h00, 8'h00, 1, 8'hFF);
    add_row(ROW_CMD, CMD_WRITE, 8'h00, 8'h0A, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_WRITE, 8'h01, 8'h00, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_WRITE, 8'hFC, 8'h0C, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_WRITE, 8'hFE, 8'h80, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd10, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd17, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd18, 0, 8'h00);
    // just past the short range of the zero entries, and below entry zero
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd8, 1, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd7, 0, 8'h00);
    add_row(ROW_CMD, CMD_UNUSED, 8'h00, 8'h55, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_READ, 8'h00, 8'h00, 8'h00, 1, 8'h0A);
    add_row(ROW_TALL, CMD_WRITE, 8'h00, 8'h01, 8'h00, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd25, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd26, 0, 8'h00);
    add_row(ROW_CMD, CMD_EVAL, 8'h00, 8'h00, 8'd15, 0, 8'h00);
    add_row(ROW_TALL, CMD_WRITE, 8'h00, 8'h00, 8'h00, 0, 8'h00);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_TALL) set_tall(script[i].cmd_item.oam_data[0]);
      else send_item(script[i].cmd_item, script[i].typed, script[i].typed_rd, 23);
    end

    phase_tall[0] = 1'b1;
    phase_tall[1] = 1'b0;
    phase_tall[2] = 1'b1;
    phase_tall[3] = 1'($urandom_range(0, 1));
    for (ph = 0; ph < 4; ph++) begin
      set_tall(phase_tall[ph]);
      // third phase runs back to back with no sender gaps
      idle_pct = (ph == 2) ? 0 : 23;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        center = 8'($urandom);
        // a cluster of Y bytes at and below the center, then mixed traffic near it
        repeat ($urandom_range(0, 12)) begin
          it.cmd = CMD_WRITE;
          it.oam_address = {6'($urandom_range(0, OAM_WORDS - 1)), 2'b00};
          it.oam_data = center - 8'($urandom_range(0, 18));
          it.scanline = 8'($urandom);
          send_item(it, 0, 8'd0, idle_pct);
          sent++;
        end
        repeat ($urandom_range(8, 20)) begin
          it = random_command(center);
          send_item(it, 0, 8'd0, idle_pct);
          if (it.cmd != CMD_UNUSED) sent++;
        end
        if ($urandom_range(99) < 10) wait_all_results();
      end
    end

    wait_all_results();
    repeat (8) @(posedge clk);

    $display("%0d commands transferred, %0d results checked", commands_taken,
             results_checked);
    $display("%0d scanlines hit overflow, %0d scans in tall mode", overflow_lines,
             tall_scans);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
